[rtl/sidta_pkg.sv]
// Shared constants, types and state encodings for the signed integer to decimal text block.
package sidta_pkg;

    // Field widths
    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = DIGIT_W * DIGITS;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Last bit index of the binary shift, last digit count
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(VALUE_W - 1);
    localparam logic [DIG_CNT_W-1:0] DIG_CNT_FULL = DIG_CNT_W'(DIGITS);
    localparam logic [DIG_CNT_W-1:0] DIG_CNT_ONE  = DIG_CNT_W'(1);

    // Converter states
    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_HOLD
    } t_conv_state;

    // Character emitter states
    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SIGN,
        EMIT_DIGIT
    } t_emit_state;

    // Finished conversion handed from converter to emitter
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv_res;

endpackage

[rtl/sidta_in_if.sv]
// Input channel: one signed integer per request.
interface sidta_in_if;
    logic                          valid;
    logic                          ready;
    logic [sidta_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[rtl/sidta_out_if.sv]
// Output channel: one ASCII character per request, with end-of-number mark.
interface sidta_out_if;
    logic                         valid;
    logic                         ready;
    logic [sidta_pkg::CHAR_W-1:0] char_code;
    logic                         last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

[rtl/sidta_dabble.sv]
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
module sidta_dabble (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sidta_pkg::VALUE_W-1:0] i_value,
    output logic                          o_ready,
    output logic                          o_res_valid,
    output sidta_pkg::t_conv_res          o_res,
    input  logic                          i_res_take
);

    sidta_pkg::t_conv_state                r_state, n_state;
    logic [sidta_pkg::BIT_CNT_W-1:0]       r_cnt, n_cnt;
    logic [sidta_pkg::VALUE_W-1:0]         r_bin, n_bin;
    logic [sidta_pkg::BCD_W-1:0]           r_bcd, n_bcd;
    logic                                  r_neg, n_neg;
    logic [sidta_pkg::BCD_W-1:0]           adj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < sidta_pkg::DIGITS; d++) begin
            if (r_bcd[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] >= 4'd5) begin
                adj[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] =
                    r_bcd[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] + 4'd3;
            end else begin
                adj[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] =
                    r_bcd[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W];
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sidta_pkg::CONV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        unique case (r_state)
            sidta_pkg::CONV_IDLE: begin
                if (i_start) begin
                    // magnitude taken as unsigned, so the most negative value is exact
                    n_neg   = i_value[sidta_pkg::VALUE_W-1];
                    n_bin   = i_value[sidta_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = sidta_pkg::CONV_SHIFT;
                end
            end
            sidta_pkg::CONV_SHIFT: begin
                n_bcd = {adj[sidta_pkg::BCD_W-2:0], r_bin[sidta_pkg::VALUE_W-1]};
                n_bin = {r_bin[sidta_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sidta_pkg::BIT_CNT_LAST) begin
                    n_state = sidta_pkg::CONV_HOLD;
                end
            end
            sidta_pkg::CONV_HOLD: begin
                if (i_res_take) begin
                    n_state = sidta_pkg::CONV_IDLE;
                end
            end
            default: begin
                n_state = sidta_pkg::CONV_IDLE;
            end
        endcase
    end

    assign o_ready     = (r_state == sidta_pkg::CONV_IDLE);
    assign o_res_valid = (r_state == sidta_pkg::CONV_HOLD);
    assign o_res.neg   = r_neg;
    assign o_res.bcd   = r_bcd;

endmodule

[rtl/sidta_emit.sv]
// Character emitter: drops leading zeros, then sends sign and digits one per request.
module sidta_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  sidta_pkg::t_conv_res i_res,
    output logic                 o_res_take,
    sidta_out_if.source          o_out
);

    sidta_pkg::t_emit_state          r_state, n_state;
    logic [sidta_pkg::BCD_W-1:0]     r_bcd, n_bcd;
    logic [sidta_pkg::DIG_CNT_W-1:0] r_cnt, n_cnt;
    logic                            r_neg, n_neg;
    logic [sidta_pkg::DIGIT_W-1:0]   top_digit;

    assign top_digit = r_bcd[sidta_pkg::BCD_W-1 -: sidta_pkg::DIGIT_W];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sidta_pkg::EMIT_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    // Next state and output
    always_comb begin
        n_state         = r_state;
        n_bcd           = r_bcd;
        n_cnt           = r_cnt;
        n_neg           = r_neg;
        o_res_take      = 1'b0;
        o_out.valid     = 1'b0;
        o_out.char_code = sidta_pkg::CHAR_ZERO + {2'b00, top_digit};
        o_out.last      = 1'b0;
        unique case (r_state)
            sidta_pkg::EMIT_IDLE: begin
                if (i_res_valid) begin
                    o_res_take = 1'b1;
                    n_bcd      = i_res.bcd;
                    n_neg      = i_res.neg;
                    n_cnt      = sidta_pkg::DIG_CNT_FULL;
                    n_state    = sidta_pkg::EMIT_SKIP;
                end
            end
            sidta_pkg::EMIT_SKIP: begin
                // one leading zero dropped per cycle, the units digit always kept
                if (top_digit == '0 && r_cnt != sidta_pkg::DIG_CNT_ONE) begin
                    n_bcd = {r_bcd[sidta_pkg::BCD_W-sidta_pkg::DIGIT_W-1:0],
                             {sidta_pkg::DIGIT_W{1'b0}}};
                    n_cnt = r_cnt - 1'b1;
                end else if (r_neg) begin
                    n_state = sidta_pkg::EMIT_SIGN;
                end else begin
                    n_state = sidta_pkg::EMIT_DIGIT;
                end
            end
            sidta_pkg::EMIT_SIGN: begin
                o_out.valid     = 1'b1;
                o_out.char_code = sidta_pkg::CHAR_MINUS;
                if (o_out.ready) begin
                    n_state = sidta_pkg::EMIT_DIGIT;
                end
            end
            sidta_pkg::EMIT_DIGIT: begin
                o_out.valid = 1'b1;
                o_out.last  = (r_cnt == sidta_pkg::DIG_CNT_ONE);
                if (o_out.ready) begin
                    n_bcd = {r_bcd[sidta_pkg::BCD_W-sidta_pkg::DIGIT_W-1:0],
                             {sidta_pkg::DIGIT_W{1'b0}}};
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == sidta_pkg::DIG_CNT_ONE) begin
                        n_state = sidta_pkg::EMIT_IDLE;
                    end
                end
            end
            default: begin
                n_state = sidta_pkg::EMIT_IDLE;
            end
        endcase
    end

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//   channel   dir  fields                     per request
//   i_in      in   value[31:0] signed         one integer
//   o_out     out  char_code[5:0], last       one character, last on final one
//
// Conversion: accept when idle, shift in the 32 bits one at a time, then hand off to the idle emitter.
// The emitter drops one leading zero per cycle (up to 9), leaves the skip state, then sends
// one character per cycle while the output is ready (up to 11); the converter works on the next
// integer meanwhile.
// Reset (synchronous, active low) returns both units to idle; a stalled output holds.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sidta_in_if.sink    i_in,
    sidta_out_if.source o_out
);

    sidta_pkg::t_conv_res conv_res;
    logic                 conv_ready;
    logic                 conv_valid;
    logic                 conv_take;

    assign i_in.ready = conv_ready;

    // Binary to BCD
    sidta_dabble u_dabble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid & conv_ready),
        .i_value     (i_in.value),
        .o_ready     (conv_ready),
        .o_res_valid (conv_valid),
        .o_res       (conv_res),
        .i_res_take  (conv_take)
    );

    // BCD to characters
    sidta_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (conv_valid),
        .i_res       (conv_res),
        .o_res_take  (conv_take),
        .o_out       (o_out)
    );

endmodule
